// File: sv/text_console_cell_writer_macros.svh
// Assertion macros for the text console cell writer.
// Used at the end of the top level; no other dependencies.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ccw_pkg.sv
// Shared types and constants for the text console cell writer.
// No dependencies; used by ccw_ctrl and text_console_cell_writer.
package ccw_pkg;

   localparam int DEF_COLS     = 80;
   localparam int DEF_ROWS     = 25;
   localparam int CHAR_W       = 8;
   localparam int ENTRY_W      = 16;
   localparam int COL_OUT_W    = 7;
   localparam int ROW_OUT_W    = 5;
   localparam int CELL_INDEX_W = 11;
   localparam int CFG_IDX_W    = 1;
   localparam int TAB_STOP     = 8;
   localparam int TAB_LOG      = 3;
   localparam int TAB_W        = 4;

   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [CHAR_W-1:0]  RESET_ATTR  = 8'd7;
   localparam logic [ENTRY_W-1:0] BLANK_RESET = {RESET_ATTR, CH_SPACE};

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_WRITE_ATTR = 1'b0,
      CFG_BLANK_ATTR = 1'b1
   } cfg_reg_type;

   typedef enum logic {
      REQ_PUT  = 1'b0,
      REQ_READ = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PUT,
      ST_SCROLL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]   entry;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_OUT_W-1:0] row;
   } rsp_type;

endpackage

// File: sv/ccw_ram.sv
// Cell store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
module ccw_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: sv/ccw_ctrl.sv
// Console sequencer: cursor, scroll offset, config registers and RAM access.
// Depends on ccw_pkg. The screen is a ring of rows; top_base marks row 0.
module ccw_ctrl #(
   parameter int COLS = ccw_pkg::DEF_COLS,
   parameter int ROWS = ccw_pkg::DEF_ROWS,
   parameter int CELLS = COLS * ROWS,
   parameter int AW = $clog2(CELLS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [ccw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [ccw_pkg::CELL_INDEX_W-1:0]  req_cell_index,
   input  logic                              csr_write_en,
   input  logic [ccw_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [ccw_pkg::CHAR_W-1:0]        csr_wdata,
   output logic                              res_valid,
   output ccw_pkg::rsp_type                  res,
   input  logic                              res_ready,
   output logic                              ram_wr_en,
   output logic [AW-1:0]                     ram_wr_addr,
   output logic [ccw_pkg::ENTRY_W-1:0]       ram_wr_data,
   output logic                              ram_rd_en,
   output logic [AW-1:0]                     ram_rd_addr,
   input  logic [ccw_pkg::ENTRY_W-1:0]       ram_rd_data
);

   localparam int CW = $clog2(COLS + 1);
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IW = ccw_pkg::CELL_INDEX_W;
   localparam int SW = ((AW > IW) ? AW : IW) + 1;

   localparam logic [AW:0]   CELLS_X  = (AW + 1)'(CELLS);
   localparam logic [SW-1:0] CELLS_S  = SW'(CELLS);
   localparam logic [AW-1:0] COLS_A   = AW'(COLS);
   localparam logic [AW:0]   COLS_X   = (AW + 1)'(COLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_COL_A = AW'(COLS - 1);
   localparam logic [CW-1:0] COLS_C   = CW'(COLS);
   localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

   ccw_pkg::state_type state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic [AW-1:0] top_base_ff, top_base_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [ccw_pkg::TAB_W-1:0] cnt_ff, cnt_in;
   logic [ccw_pkg::CHAR_W-1:0] ch_ff, ch_in;
   logic [ccw_pkg::ENTRY_W-1:0] entry_ff, entry_in;
   logic ret_put_ff, ret_put_in;
   logic [ccw_pkg::CHAR_W-1:0] wattr_ff, battr_ff;

   logic [AW:0]   cur_sum, top_next;
   logic [AW-1:0] cur_addr, top_wrap;
   logic [SW-1:0] idx_ext, rd_sum;
   logic          idx_ok, last_row;

   // physical address of the cursor cell and of a requested cell
   assign cur_sum  = {1'b0, top_base_ff} + {1'b0, row_base_ff} + (AW + 1)'(col_ff);
   assign cur_addr = (cur_sum >= CELLS_X) ? AW'(cur_sum - CELLS_X) : AW'(cur_sum);
   assign idx_ext  = SW'(req_cell_index);
   assign idx_ok   = idx_ext < CELLS_S;
   assign rd_sum   = idx_ext + SW'(top_base_ff);
   assign top_next = {1'b0, top_base_ff} + COLS_X;
   assign top_wrap = (top_next == CELLS_X) ? '0 : AW'(top_next);
   assign last_row = row_ff == LAST_ROW;

   always_ff @(posedge clock) begin
      if (reset) begin
         wattr_ff <= ccw_pkg::RESET_ATTR;
         battr_ff <= ccw_pkg::RESET_ATTR;
      end else if (csr_write_en) begin
         unique case (ccw_pkg::cfg_reg_type'(csr_index))
            ccw_pkg::CFG_WRITE_ATTR: wattr_ff <= csr_wdata;
            ccw_pkg::CFG_BLANK_ATTR: battr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ccw_pkg::ST_CLEAR;
         col_ff      <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
         top_base_ff <= '0;
         sweep_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         row_base_ff <= row_base_in;
         top_base_ff <= top_base_in;
         sweep_ff    <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      ch_ff      <= ch_in;
      entry_ff   <= entry_in;
      ret_put_ff <= ret_put_in;
   end

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      row_base_in = row_base_ff;
      top_base_in = top_base_ff;
      sweep_in    = sweep_ff;
      cnt_in      = cnt_ff;
      ch_in       = ch_ff;
      entry_in    = entry_ff;
      ret_put_in  = ret_put_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_addr;
      ram_wr_data = {wattr_ff, ch_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = (rd_sum >= CELLS_S) ? AW'(rd_sum - CELLS_S) : AW'(rd_sum);

      unique case (state_ff)
         ccw_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = ccw_pkg::BLANK_RESET;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ccw_pkg::ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ccw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               entry_in = '0;
               if (req_type == ccw_pkg::REQ_READ) begin
                  ram_rd_en = idx_ok;
                  state_in  = idx_ok ? ccw_pkg::ST_READ : ccw_pkg::ST_DONE;
               end else begin
                  state_in = ccw_pkg::ST_DONE;
                  unique case (req_char_code)
                     ccw_pkg::CH_NL: begin
                        col_in = '0;
                        if (last_row) begin
                           ret_put_in = 1'b0;
                           sweep_in   = '0;
                           state_in   = ccw_pkg::ST_SCROLL;
                        end else begin
                           row_in      = row_ff + RW'(1);
                           row_base_in = row_base_ff + COLS_A;
                        end
                     end
                     ccw_pkg::CH_CR: col_in = '0;
                     ccw_pkg::CH_BS: begin
                        if (col_ff != '0) begin
                           col_in = col_ff - CW'(1);
                        end else if (row_ff != '0) begin
                           row_in      = row_ff - RW'(1);
                           row_base_in = row_base_ff - COLS_A;
                           col_in      = LAST_COL;
                        end
                     end
                     ccw_pkg::CH_TAB: begin
                        cnt_in   = ccw_pkg::TAB_W'(ccw_pkg::TAB_STOP)
                                 - ccw_pkg::TAB_W'(col_ff[ccw_pkg::TAB_LOG-1:0]);
                        ch_in    = ccw_pkg::CH_SPACE;
                        state_in = ccw_pkg::ST_PUT;
                     end
                     default: begin
                        cnt_in   = ccw_pkg::TAB_W'(1);
                        ch_in    = req_char_code;
                        state_in = ccw_pkg::ST_PUT;
                     end
                  endcase
               end
            end
         end
         ccw_pkg::ST_READ: begin
            entry_in = ram_rd_data;
            state_in = ccw_pkg::ST_DONE;
         end
         ccw_pkg::ST_PUT: begin
            if (col_ff >= COLS_C) begin
               // wrap pending: new line first, then write on a later cycle
               col_in = '0;
               if (last_row) begin
                  ret_put_in = 1'b1;
                  sweep_in   = '0;
                  state_in   = ccw_pkg::ST_SCROLL;
               end else begin
                  row_in      = row_ff + RW'(1);
                  row_base_in = row_base_ff + COLS_A;
               end
            end else begin
               ram_wr_en = 1'b1;
               col_in    = col_ff + CW'(1);
               cnt_in    = cnt_ff - ccw_pkg::TAB_W'(1);
               if (cnt_ff == ccw_pkg::TAB_W'(1)) begin
                  state_in = ccw_pkg::ST_DONE;
               end
            end
         end
         ccw_pkg::ST_SCROLL: begin
            // blank the old top row, which becomes the new bottom row
            ram_wr_en   = 1'b1;
            ram_wr_addr = top_base_ff + sweep_ff;
            ram_wr_data = {battr_ff, ccw_pkg::CH_SPACE};
            if (sweep_ff == LAST_COL_A) begin
               sweep_in    = '0;
               top_base_in = top_wrap;
               state_in    = ret_put_ff ? ccw_pkg::ST_PUT : ccw_pkg::ST_DONE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ccw_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ccw_pkg::ST_IDLE;
            end
         end
         default: state_in = ccw_pkg::ST_IDLE;
      endcase
   end

   assign res.entry = entry_ff;
   assign res.col   = ccw_pkg::COL_OUT_W'(col_ff);
   assign res.row   = ccw_pkg::ROW_OUT_W'(row_ff);

endmodule

// File: sv/text_console_cell_writer.sv
// Text console cell writer top level: sequencer, cell RAM, response register.
// Depends on ccw_pkg, ccw_ram, ccw_ctrl and text_console_cell_writer_macros.svh.
//
//   channel | ports                                      | direction
//   req     | req_valid/ready, type, char_code, cell_index | in
//   rsp     | rsp_valid/ready, cell_entry, cursor_col/row | out
//   csr     | csr_write_en, csr_index, csr_wdata         | in, write only
//
// CR, BS and LF (not on last row) go straight to ST_DONE; a read takes its data in
// ST_READ; a byte or tab writes in ST_PUT, a tab padding to a multiple of 8 columns.
// A pending wrap adds a line feed first. A scroll blanks a row cell by cell through
// the single RAM write port. After reset the RAM is cleared one cell a cycle, with
// req_ready low. A request is taken while the previous response waits in the output
// register; the sequencer holds its finished response until that register frees up.
`include "text_console_cell_writer_macros.svh"

module text_console_cell_writer #(
   parameter int COLS = ccw_pkg::DEF_COLS,
   parameter int ROWS = ccw_pkg::DEF_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [ccw_pkg::CHAR_W-1:0]          req_char_code,
   input  logic [ccw_pkg::CELL_INDEX_W-1:0]    req_cell_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ccw_pkg::ENTRY_W-1:0]         rsp_cell_entry,
   output logic [ccw_pkg::COL_OUT_W-1:0]       rsp_cursor_col,
   output logic [ccw_pkg::ROW_OUT_W-1:0]       rsp_cursor_row,
   input  logic                                csr_write_en,
   input  logic [ccw_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [ccw_pkg::CHAR_W-1:0]          csr_wdata
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam logic [AW:0] CELLS_X = (AW + 1)'(CELLS);

   logic              res_valid, res_ready;
   ccw_pkg::rsp_type  res;
   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [ccw_pkg::ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   logic              rsp_valid_ff;
   ccw_pkg::rsp_type  rsp_ff;

   ccw_ctrl #(
      .COLS (COLS),
      .ROWS (ROWS),
      .CELLS(CELLS),
      .AW   (AW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_cell_index(req_cell_index),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .res_valid     (res_valid),
      .res           (res),
      .res_ready     (res_ready),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   ccw_ram #(
      .DEPTH (CELLS),
      .ADDR_W(AW),
      .DATA_W(ccw_pkg::ENTRY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr   (ram_rd_addr),
      .rd_data_ff(ram_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_entry = rsp_ff.entry;
   assign rsp_cursor_col = rsp_ff.col;
   assign rsp_cursor_row = rsp_ff.row;

   `CCW_ASSERT_SAME(a_wr_in_range, clock, reset, ram_wr_en, {1'b0, ram_wr_addr} < CELLS_X, "cell write address past end of store")
   `CCW_ASSERT_SAME(a_rd_in_range, clock, reset, ram_rd_en, {1'b0, ram_rd_addr} < CELLS_X, "cell read address past end of store")
   `CCW_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while previous one still in work")
   `CCW_ASSERT_SAME(a_result_not_idle, clock, reset, res_valid, !req_ready, "response offered while sequencer is idle")

endmodule

// File: dv/console_screen_checker.sv
// Checker for the text console cell writer: mirrors the screen, cursor and attributes,
// predicts one response per accepted request and compares it field by field.
// Depends on ccw_pkg.
`timescale 1ns / 1ps

module console_screen_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_type,
   input  logic [ccw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [ccw_pkg::CELL_INDEX_W-1:0] req_cell_index,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [ccw_pkg::ENTRY_W-1:0]      rsp_cell_entry,
   input  logic [ccw_pkg::COL_OUT_W-1:0]    rsp_cursor_col,
   input  logic [ccw_pkg::ROW_OUT_W-1:0]    rsp_cursor_row,
   input  logic                             csr_write_en,
   input  logic [ccw_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [ccw_pkg::CHAR_W-1:0]       csr_wdata,
   output int unsigned                      fail_count,
   output int unsigned                      outstanding
);

   localparam int COLS  = ccw_pkg::DEF_COLS;
   localparam int ROWS  = ccw_pkg::DEF_ROWS;
   localparam int CELLS = COLS * ROWS;

   logic [ccw_pkg::ENTRY_W-1:0] screen [CELLS];
   int unsigned                 cur_col;
   int unsigned                 cur_row;
   logic [ccw_pkg::CHAR_W-1:0]  attr_write;
   logic [ccw_pkg::CHAR_W-1:0]  attr_blank;
   ccw_pkg::rsp_type            pending_rsp [$];

   function automatic void clear_screen();
      cur_col    = 0;
      cur_row    = 0;
      attr_write = ccw_pkg::RESET_ATTR;
      attr_blank = ccw_pkg::RESET_ATTR;
      for (int i = 0; i < CELLS; i++) screen[i] = ccw_pkg::BLANK_RESET;
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr_blank, ccw_pkg::CH_SPACE};
         cur_row = ROWS - 1;
      end
   endfunction

   function automatic void store_glyph(logic [ccw_pkg::CHAR_W-1:0] ch);
      // column COLS means wrap pending: the line feed happens on the next glyph
      if (cur_col >= COLS) line_feed();
      screen[cur_row * COLS + cur_col] = {attr_write, ch};
      cur_col++;
   endfunction

   function automatic void apply_put(logic [ccw_pkg::CHAR_W-1:0] ch);
      int unsigned spaces;
      if (ch == ccw_pkg::CH_NL) begin
         line_feed();
      end else if (ch == ccw_pkg::CH_CR) begin
         cur_col = 0;
      end else if (ch == ccw_pkg::CH_TAB) begin
         spaces = ccw_pkg::TAB_STOP - (cur_col % ccw_pkg::TAB_STOP);
         repeat (spaces) store_glyph(ccw_pkg::CH_SPACE);
      end else if (ch == ccw_pkg::CH_BS) begin
         if (cur_col > 0) begin
            cur_col--;
         end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
         end
      end else begin
         store_glyph(ch);
      end
   endfunction

   function automatic ccw_pkg::rsp_type next_response(ccw_pkg::req_kind_type kind,
                                                      logic [ccw_pkg::CHAR_W-1:0] ch,
                                                      logic [ccw_pkg::CELL_INDEX_W-1:0] idx);
      ccw_pkg::rsp_type r;
      r.entry = '0;
      if (kind == ccw_pkg::REQ_PUT) apply_put(ch);
      else if (idx < CELLS) r.entry = screen[idx];
      r.col = ccw_pkg::COL_OUT_W'(cur_col);
      r.row = ccw_pkg::ROW_OUT_W'(cur_row);
      return r;
   endfunction

   always @(posedge clock) begin
      ccw_pkg::rsp_type want;
      if (reset) begin
         clear_screen();
         pending_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) begin
            case (ccw_pkg::cfg_reg_type'(csr_index))
               ccw_pkg::CFG_WRITE_ATTR: attr_write = csr_wdata;
               ccw_pkg::CFG_BLANK_ATTR: attr_blank = csr_wdata;
               default: ;
            endcase
         end
         // response side first: a response can never belong to a request taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_cell_entry !== want.entry) begin
                  $error("cell_entry: expected %h, got %h", want.entry, rsp_cell_entry);
                  fail_count++;
               end
               if (rsp_cursor_col !== want.col) begin
                  $error("cursor_col: expected %0d, got %0d", want.col, rsp_cursor_col);
                  fail_count++;
               end
               if (rsp_cursor_row !== want.row) begin
                  $error("cursor_row: expected %0d, got %0d", want.row, rsp_cursor_row);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_rsp.push_back(next_response(ccw_pkg::req_kind_type'(req_type),
                                                req_char_code, req_cell_index));
      end
      outstanding = pending_rsp.size();
   end

endmodule

// File: dv/tb_text_console_cell_writer.sv
// Testbench top for the text console cell writer: clock, reset, request traffic,
// response back-pressure and attribute writes. Checking is done by console_screen_checker.
// Depends on ccw_pkg, text_console_cell_writer and console_screen_checker.
`timescale 1ns / 1ps

module tb_text_console_cell_writer;

   localparam int CYCLE_LIMIT = 600000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_type;
   logic [ccw_pkg::CHAR_W-1:0]       req_char_code;
   logic [ccw_pkg::CELL_INDEX_W-1:0] req_cell_index;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [ccw_pkg::ENTRY_W-1:0]      rsp_cell_entry;
   logic [ccw_pkg::COL_OUT_W-1:0]    rsp_cursor_col;
   logic [ccw_pkg::ROW_OUT_W-1:0]    rsp_cursor_row;
   logic                             csr_write_en;
   logic [ccw_pkg::CFG_IDX_W-1:0]    csr_index;
   logic [ccw_pkg::CHAR_W-1:0]       csr_wdata;

   int unsigned                      fail_count;
   int unsigned                      outstanding;
   int unsigned                      items_sent = 0;
   int unsigned                      send_idle_pct = 0;
   int unsigned                      recv_stall_pct = 0;
   logic [ccw_pkg::ROW_OUT_W-1:0]    last_row = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   text_console_cell_writer dut (.*);

   console_screen_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (rsp_valid && rsp_ready) last_row <= rsp_cursor_row;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_request(ccw_pkg::req_kind_type kind, logic [ccw_pkg::CHAR_W-1:0] ch,
                               logic [ccw_pkg::CELL_INDEX_W-1:0] idx);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_char_code  <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic put_char(logic [ccw_pkg::CHAR_W-1:0] ch);
      send_request(ccw_pkg::REQ_PUT, ch, ccw_pkg::CELL_INDEX_W'($urandom));
   endtask

   task automatic read_cell(logic [ccw_pkg::CELL_INDEX_W-1:0] idx);
      send_request(ccw_pkg::REQ_READ, ccw_pkg::CHAR_W'($urandom), idx);
   endtask

   // drop valid and wait until every request has been answered
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic set_attrs(logic [ccw_pkg::CHAR_W-1:0] wr, logic [ccw_pkg::CHAR_W-1:0] blank);
      csr_write_en <= 1'b1;
      csr_index    <= ccw_pkg::CFG_WRITE_ATTR;
      csr_wdata    <= wr;
      @(posedge clock);
      csr_index    <= ccw_pkg::CFG_BLANK_ATTR;
      csr_wdata    <= blank;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_burst();
      int unsigned pick;
      int unsigned row_sel;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // a line of text, long enough at times to wrap
         repeat ($urandom_range(90, 5))
            put_char(($urandom_range(10) == 0) ? ccw_pkg::CHAR_W'($urandom)
                                               : ccw_pkg::CHAR_W'($urandom_range(126, 33)));
      end else if (pick < 45) begin
         repeat ($urandom_range(30, 1)) begin
            if ($urandom_range(3) == 0) put_char(ccw_pkg::CH_CR);
            put_char(ccw_pkg::CH_NL);
         end
      end else if (pick < 58) begin
         repeat ($urandom_range(12, 1)) begin
            put_char(ccw_pkg::CH_TAB);
            if ($urandom_range(1) != 0) put_char(ccw_pkg::CHAR_W'($urandom_range(126, 33)));
         end
      end else if (pick < 66) begin
         repeat ($urandom_range(90, 1)) put_char(ccw_pkg::CH_BS);
      end else if (pick < 88) begin
         // reads around the cursor row, where the writes land
         repeat ($urandom_range(8, 1)) begin
            row_sel = (last_row > 0 && $urandom_range(3) == 0) ? last_row - 1 : last_row;
            read_cell(ccw_pkg::CELL_INDEX_W'(row_sel * ccw_pkg::DEF_COLS
                                             + $urandom_range(ccw_pkg::DEF_COLS - 1)));
         end
      end else begin
         repeat ($urandom_range(6, 1))
            send_request(ccw_pkg::req_kind_type'($urandom_range(1)),
                         ccw_pkg::CHAR_W'($urandom), ccw_pkg::CELL_INDEX_W'($urandom));
      end
   endtask

   task automatic run_traffic(int unsigned quota);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < quota) random_burst();
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= ccw_pkg::REQ_PUT;
      req_char_code  <= '0;
      req_cell_index <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= ccw_pkg::CFG_WRITE_ATTR;
      csr_wdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // ready stays low while the screen is being cleared
      do @(posedge clock); while (!req_ready);

      read_cell(0);
      read_cell(ccw_pkg::CELL_INDEX_W'(ccw_pkg::DEF_COLS * ccw_pkg::DEF_ROWS - 1));
      put_char(ccw_pkg::CH_BS);      // top-left: cursor stays
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h41);
      put_char(ccw_pkg::CH_TAB);     // partial tab to column 8
      put_char(ccw_pkg::CH_TAB);     // full tab of 8 spaces
      read_cell(3);
      read_cell(10);
      put_char(ccw_pkg::CH_CR);
      put_char(ccw_pkg::CH_NL);
      put_char(ccw_pkg::CH_BS);      // column 0: back to end of previous row
      put_char(8'h5A);               // last column, leaves wrap pending
      read_cell(ccw_pkg::CELL_INDEX_W'(ccw_pkg::DEF_COLS - 1));
      put_char(8'h79);               // wraps before writing
      read_cell(ccw_pkg::CELL_INDEX_W'(ccw_pkg::DEF_COLS));
      read_cell(ccw_pkg::CELL_INDEX_W'(ccw_pkg::DEF_COLS * ccw_pkg::DEF_ROWS));
      read_cell('1);
      run_traffic(70);

      wait_idle();
      set_attrs(8'h00, 8'hFF);
      send_idle_pct = 66;
      run_traffic(90);

      wait_idle();
      set_attrs(8'hFF, 8'h00);
      send_idle_pct  = 0;
      recv_stall_pct = 66;
      run_traffic(90);

      wait_idle();
      set_attrs(ccw_pkg::CHAR_W'($urandom), ccw_pkg::CHAR_W'($urandom));
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      run_traffic(90);

      wait_idle();
      set_attrs(ccw_pkg::CHAR_W'($urandom), ccw_pkg::CHAR_W'($urandom));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_traffic(90);

      wait_idle();
      repeat (4 * ccw_pkg::DEF_COLS) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
